FILE: hdl/ktb_pkg.sv
// Shared types and constants for the keyframe timeline bracket block.
// Used by the core, the serial divider and the checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ktb_pkg;

  // Time values are unsigned Q16.8.
  localparam int TIME_W = 24;
  // Width of the slot index fields in a result.
  localparam int IDX_W = 5;
  // Width of the Q0.16 mix fraction.
  localparam int MIX_W = 16;
  // Divider dividend width: covers the magnitude of any unwrapped time.
  localparam int DIV_NUM_W = TIME_W + 1;
  // Width of the divider step counter.
  localparam int DIV_CNT_W = 5;
  // Steps of the wrap remainder and of the mix quotient.
  localparam logic [DIV_CNT_W-1:0] MOD_STEPS = DIV_CNT_W'(DIV_NUM_W);
  localparam logic [DIV_CNT_W-1:0] MIX_STEPS = DIV_CNT_W'(MIX_W);
  // Animation length after reset.
  localparam logic [TIME_W-1:0] LEN_RESET = TIME_W'(256);

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_DUP   = 2'd2,
    STATUS_FULL  = 2'd3
  } status_e;

  // One request item.
  typedef struct packed {
    logic                     req_type;
    logic signed [TIME_W-1:0] delta;
    logic                     loop_mode;
    logic [TIME_W-1:0]        key_time;
  } req_t;

  // One result item.
  typedef struct packed {
    status_e           status;
    logic [TIME_W-1:0] new_time;
    logic              end_reached;
    logic [IDX_W-1:0]  prev_index;
    logic              prev_valid;
    logic [IDX_W-1:0]  next_index;
    logic              next_valid;
    logic              exact_hit;
    logic [MIX_W-1:0]  mix;
  } rsp_t;

  // Command to the shared serial divider.
  typedef struct packed {
    logic                 start;
    logic [TIME_W-1:0]    init_rem;
    logic [DIV_NUM_W-1:0] numer;
    logic [TIME_W-1:0]    den;
    logic [DIV_CNT_W-1:0] steps;
  } div_cmd_t;

  // Result of the shared serial divider.
  typedef struct packed {
    logic                 done;
    logic [TIME_W-1:0]    rem;
    logic [DIV_NUM_W-1:0] quo;
  } div_res_t;

endpackage

`default_nettype wire

FILE: hdl/ktb_stream_if.sv
// Valid/ready stream interface used for the request and result channels.
// The payload type is chosen per instance, normally a struct from ktb_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ktb_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hdl/ktb_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Serves both the loop-mode wrap remainder and the mix fraction.
// Depends on ktb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ktb_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ktb_pkg::div_cmd_t cmd_i,
  output ktb_pkg::div_res_t res_o
);
  import ktb_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [TIME_W-1:0]    rem_q;
  logic [DIV_NUM_W-1:0] num_q;
  logic [DIV_NUM_W-1:0] quo_q;
  logic [TIME_W-1:0]    den_q;

  logic [TIME_W:0]      trial;
  logic                 fits;
  logic [TIME_W:0]      diff;

  // One step: shift the next dividend bit into the partial remainder and subtract if it fits.
  always_comb begin
    trial = {rem_q, num_q[DIV_NUM_W-1]};
    fits  = trial >= {1'b0, den_q};
    diff  = trial - {1'b0, den_q};
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= cmd_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder, dividend and quotient shift registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start && !busy_q) begin
      rem_q <= cmd_i.init_rem;
      num_q <= cmd_i.numer;
      den_q <= cmd_i.den;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      num_q <= {num_q[DIV_NUM_W-2:0], 1'b0};
      quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
    end
  end

  assign res_o.done = done_q;
  assign res_o.rem  = rem_q;
  assign res_o.quo  = quo_q;

endmodule

`default_nettype wire

FILE: hdl/keyframe_timeline_bracket_core.sv
// Keyframe timeline bracket search: keyframe table, playback time and result register.
// Depends on ktb_pkg, ktb_stream_if and ktb_div.
//
// Usage: requests arrive on the req stream (valid/ready, payload ktb_pkg::req_t) and one
// result per request leaves on the rsp stream (payload ktb_pkg::rsp_t). A request with
// req_type 1 adds a keyframe time; one with req_type 0 moves the playback time by delta,
// wrapping in loop mode and clamping otherwise. Every result reports the keyframes that
// bracket the playback time and the Q0.16 mix fraction between them. The animation length
// is to be written through cfg_we_i/cfg_wdata_i only while the block is idle; the block
// itself does not enforce this. A zero write is ignored.
// The table is read one slot per cycle from its registered memory port; a bracket scan
// visits all MAX_KEYFRAMES slots. An advance may first compute the loop wrap remainder, and
// the mix fraction is computed when the time lies strictly between two keyframes; both run
// on the shared bit-serial divider. An add runs a duplicate scan before the bracket scan,
// which may then need the mix fraction too. One request is in work at a time; req.ready is
// high only while the block is idle.
//
// A finished result waits in an output register, so a stalled receiver does not stop the
// next request from being accepted; the block then holds its next result until the
// register frees. Reset empties the table, sets the time to zero and the length to 256.
`timescale 1ns / 1ps
`default_nettype none

module keyframe_timeline_bracket_core #(
  parameter int MAX_KEYFRAMES = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ktb_pkg::TIME_W-1:0]   cfg_wdata_i,
  ktb_stream_if.sink                   req,
  ktb_stream_if.source                 rsp
);
  import ktb_pkg::*;

  localparam int AW = (MAX_KEYFRAMES > 1) ? $clog2(MAX_KEYFRAMES) : 1;
  localparam int CW = $clog2(MAX_KEYFRAMES + 1);
  localparam logic [CW-1:0] SCAN_END = CW'(MAX_KEYFRAMES);
  localparam int TP_W = TIME_W + 2;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADV  = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  req_t req_pl;
  assign req_pl = req.payload;

  // Sequencer and configuration state.
  logic [2:0]        state_q, state_d;
  logic [TIME_W-1:0] len_q;
  logic [TIME_W-1:0] cur_q, cur_d;
  logic signed [TP_W-1:0] tp_q, tp_d;
  logic              loop_q, loop_d;
  logic              neg_q, neg_d;
  logic [TIME_W-1:0] kt_q, kt_d;
  status_e           status_q, status_d;
  logic              end_q, end_d;
  logic [MIX_W-1:0]  mix_q, mix_d;

  // Table storage.
  logic [TIME_W-1:0]        key_mem [MAX_KEYFRAMES];
  logic [MAX_KEYFRAMES-1:0] used_q;
  logic                     mem_we;
  logic [AW-1:0]            rd_addr;
  logic [TIME_W-1:0]        rd_data_q;

  // Scan pipeline.
  logic [CW-1:0] idx_q;
  logic          pipe_vld_q;
  logic          pipe_used_q;
  logic [AW-1:0] pipe_idx_q;
  logic          scanning, scan_issue, scan_done, scan_start;

  // Scan findings.
  logic              dup_q, dup_d;
  logic              free_vld_q, free_vld_d;
  logic [AW-1:0]     free_q, free_d;
  logic              hit_q, hit_d;
  logic              hp_q, hp_d;
  logic              hn_q, hn_d;
  logic [AW-1:0]     pi_q, pi_d;
  logic [AW-1:0]     ni_q, ni_d;
  logic [TIME_W-1:0] pt_q, pt_d;
  logic [TIME_W-1:0] nt_q, nt_d;

  // Output register.
  logic rsp_vld_q;
  rsp_t rsp_q;
  logic rsp_load;

  // Shared divider.
  div_cmd_t div_cmd;
  div_res_t div_res;

  logic signed [TP_W-1:0] len_s;
  logic                   tp_above, tp_below;
  logic [TP_W-1:0]        tp_dec, tp_abs;

  assign len_s    = $signed({2'b00, len_q});
  assign tp_above = tp_q > len_s;
  assign tp_below = tp_q[TP_W-1];
  assign tp_dec   = tp_q - TP_W'(1);
  assign tp_abs   = -tp_q;

  assign scanning   = (state_q == S_CHK) || (state_q == S_SCAN);
  assign scan_issue = scanning && (idx_q != SCAN_END);
  assign scan_done  = scanning && (idx_q == SCAN_END) && !pipe_vld_q;
  assign rd_addr    = idx_q[AW-1:0];

  assign req.ready   = (state_q == S_IDLE);
  assign rsp.valid   = rsp_vld_q;
  assign rsp.payload = rsp_q;

  ktb_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (div_cmd),
    .res_o (div_res)
  );

  // Keyframe time memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[free_q] <= kt_q;
    end
    rd_data_q <= key_mem[rd_addr];
  end

  // Sequencer, scan evaluation and result assembly.
  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    tp_d       = tp_q;
    loop_d     = loop_q;
    neg_d      = neg_q;
    kt_d       = kt_q;
    status_d   = status_q;
    end_d      = end_q;
    mix_d      = mix_q;
    dup_d      = dup_q;
    free_vld_d = free_vld_q;
    free_d     = free_q;
    hit_d      = hit_q;
    hp_d       = hp_q;
    hn_d       = hn_q;
    pi_d       = pi_q;
    ni_d       = ni_q;
    pt_d       = pt_q;
    nt_d       = nt_q;
    scan_start = 1'b0;
    mem_we     = 1'b0;
    rsp_load   = 1'b0;
    div_cmd    = '0;

    // Evaluate the slot read in the previous cycle.
    if (pipe_vld_q) begin
      if (state_q == S_CHK) begin
        if (pipe_used_q && (rd_data_q == kt_q)) begin
          dup_d = 1'b1;
        end
        if (!pipe_used_q && !free_vld_q) begin
          free_vld_d = 1'b1;
          free_d     = pipe_idx_q;
        end
      end else if (pipe_used_q && !hit_q) begin
        if (rd_data_q == cur_q) begin
          hit_d = 1'b1;
          hp_d  = 1'b1;
          pi_d  = pipe_idx_q;
        end else if (rd_data_q < cur_q) begin
          if (!hp_q || (rd_data_q > pt_q)) begin
            hp_d = 1'b1;
            pt_d = rd_data_q;
            pi_d = pipe_idx_q;
          end
        end else if (!hn_q || (rd_data_q < nt_q)) begin
          hn_d = 1'b1;
          nt_d = rd_data_q;
          ni_d = pipe_idx_q;
        end
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (req.valid) begin
          status_d = STATUS_OK;
          end_d    = 1'b0;
          if (req_pl.req_type) begin
            kt_d       = req_pl.key_time;
            scan_start = 1'b1;
            state_d    = S_CHK;
          end else begin
            tp_d    = $signed({2'b00, cur_q})
                    + $signed({{2{req_pl.delta[TIME_W-1]}}, req_pl.delta});
            loop_d  = req_pl.loop_mode;
            state_d = S_ADV;
          end
        end
      end
      S_ADV: begin
        if (loop_q && (tp_above || tp_below)) begin
          // Wrap needs a remainder by the length.
          neg_d            = tp_below;
          div_cmd.start    = 1'b1;
          div_cmd.init_rem = '0;
          div_cmd.numer    = tp_below ? tp_abs[DIV_NUM_W-1:0] : tp_dec[DIV_NUM_W-1:0];
          div_cmd.den      = len_q;
          div_cmd.steps    = MOD_STEPS;
          state_d          = S_MOD;
        end else begin
          if (tp_above) begin
            cur_d = len_q;
            end_d = 1'b1;
          end else if (tp_below) begin
            cur_d = '0;
            end_d = 1'b1;
          end else begin
            cur_d = tp_q[TIME_W-1:0];
          end
          scan_start = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_MOD: begin
        if (div_res.done) begin
          if (neg_q) begin
            cur_d = (div_res.rem == '0) ? '0 : len_q - div_res.rem;
          end else begin
            cur_d = div_res.rem + TIME_W'(1);
          end
          scan_start = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_CHK: begin
        if (scan_done) begin
          priority if (kt_q > len_q) begin
            status_d = STATUS_RANGE;
          end else if (dup_q) begin
            status_d = STATUS_DUP;
          end else if (!free_vld_q) begin
            status_d = STATUS_FULL;
          end else begin
            mem_we = 1'b1;
          end
          scan_start = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          if (!hit_q && hp_q && hn_q) begin
            div_cmd.start    = 1'b1;
            div_cmd.init_rem = cur_q - pt_q;
            div_cmd.numer    = '0;
            div_cmd.den      = nt_q - pt_q;
            div_cmd.steps    = MIX_STEPS;
            state_d          = S_DIV;
          end else begin
            mix_d   = '0;
            state_d = S_DONE;
          end
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          mix_d   = div_res.quo[MIX_W-1:0];
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!rsp_vld_q || rsp.ready) begin
          rsp_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A new scan starts with empty findings.
    if (scan_start) begin
      dup_d      = 1'b0;
      free_vld_d = 1'b0;
      hit_d      = 1'b0;
      hp_d       = 1'b0;
      hn_d       = 1'b0;
      pi_d       = '0;
      ni_d       = '0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      len_q      <= LEN_RESET;
      cur_q      <= '0;
      used_q     <= '0;
      idx_q      <= '0;
      pipe_vld_q <= 1'b0;
      rsp_vld_q  <= 1'b0;
      dup_q      <= 1'b0;
      free_vld_q <= 1'b0;
      hit_q      <= 1'b0;
      hp_q       <= 1'b0;
      hn_q       <= 1'b0;
      pi_q       <= '0;
      ni_q       <= '0;
    end else begin
      state_q    <= state_d;
      cur_q      <= cur_d;
      dup_q      <= dup_d;
      free_vld_q <= free_vld_d;
      hit_q      <= hit_d;
      hp_q       <= hp_d;
      hn_q       <= hn_d;
      pi_q       <= pi_d;
      ni_q       <= ni_d;
      pipe_vld_q <= scan_issue;
      if (cfg_we_i && (cfg_wdata_i != '0)) begin
        len_q <= cfg_wdata_i;
      end
      if (mem_we) begin
        used_q[free_q] <= 1'b1;
      end
      if (scan_start) begin
        idx_q <= '0;
      end else if (scan_issue) begin
        idx_q <= idx_q + CW'(1);
      end
      if (rsp_load) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp.ready) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    tp_q        <= tp_d;
    loop_q      <= loop_d;
    neg_q       <= neg_d;
    kt_q        <= kt_d;
    status_q    <= status_d;
    end_q       <= end_d;
    mix_q       <= mix_d;
    free_q      <= free_d;
    pt_q        <= pt_d;
    nt_q        <= nt_d;
    pipe_used_q <= used_q[rd_addr];
    pipe_idx_q  <= rd_addr;
    if (rsp_load) begin
      rsp_q.status      <= status_q;
      rsp_q.new_time    <= cur_q;
      rsp_q.end_reached <= end_q;
      rsp_q.prev_index  <= IDX_W'(pi_q);
      rsp_q.prev_valid  <= hp_q;
      rsp_q.next_index  <= hit_q ? '0 : IDX_W'(ni_q);
      rsp_q.next_valid  <= hn_q && !hit_q;
      rsp_q.exact_hit   <= hit_q;
      rsp_q.mix         <= mix_q;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ktb_chk.sv
// Port-level checker for keyframe_timeline_bracket_core, attached by bind.
// Depends on ktb_pkg and the core's stream ports.
`timescale 1ns / 1ps
`default_nettype none

module ktb_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          req_valid,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input ktb_pkg::rsp_t rsp_payload
);
  import ktb_pkg::*;

  // A stalled result stays offered.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> $stable(rsp_payload))
    else $error("result changed while stalled");

  // Only one request is in work: ready drops after each input transfer.
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while another is in work");

  // An exact hit reports a valid earlier keyframe, no later keyframe and no mix.
  a_hit_bracket: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_payload.exact_hit |->
      !rsp_payload.next_valid && (rsp_payload.mix == '0) && rsp_payload.prev_valid)
    else $error("exact hit with a later keyframe or a mix");

  // A rejected add never moves or clamps the time.
  a_reject_no_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && (rsp_payload.status != STATUS_OK) |-> !rsp_payload.end_reached)
    else $error("rejected add reports end reached");

endmodule

bind keyframe_timeline_bracket_core ktb_chk u_ktb_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_payload(rsp.payload)
);

`default_nettype wire
